/* design/mafhd_pkg.sv */
// ----------------------------------------------------------------------------
// mafhd_pkg
// Shared types, status codes and ISO lookup tables for the MPEG audio frame
// header decoder.
// ----------------------------------------------------------------------------
package mafhd_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SYNC  = 2'd1,
    ST_FREE_FMT = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

  // Quotient, numerator and divisor widths of the frame size division.
  localparam int unsigned QW = 12;
  localparam int unsigned NW = 26;
  localparam int unsigned DW = 16;

  localparam logic [17:0] L1_SCALE  = 18'd12000;
  localparam logic [17:0] L23_SCALE = 18'd144000;
  localparam logic [12:0] DEC_L1    = 13'd768;
  localparam logic [12:0] DEC_L23   = 13'd2304;
  localparam logic [1:0]  MODE_MONO = 2'd3;
  localparam logic [1:0]  LAYER_1   = 2'd1;
  localparam logic [1:0]  LAYER_3   = 2'd3;

  localparam logic [15:0] RATE_TAB [9] = '{
    16'd44100, 16'd48000, 16'd32000, 16'd22050, 16'd24000,
    16'd16000, 16'd11025, 16'd12000, 16'd8000
  };

  // Row is 3 * lsf + (layer - 1), column is the bitrate index.
  localparam logic [8:0] KBPS_TAB [6][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  typedef struct packed {
    status_t     status;
    logic [1:0]  layer;
    logic        is_mpeg25;
    logic        is_lsf;
    logic        protection_bit;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic        padding;
    logic [15:0] sample_rate_hz;
    logic [8:0]  bitrate_kbps;
    logic [12:0] decode_bytes;
  } hdr_t;

  typedef struct packed {
    hdr_t          hdr;
    logic [NW-1:0] numer;
    logic [DW-1:0] denom;
    logic          layer1;
    logic          halve;
    logic          ok;
  } job_t;

  typedef struct packed {
    job_t          job;
    logic [QW-1:0] quot;
  } div_stage_t;

endpackage

/* design/mafhd_front.sv */
// ----------------------------------------------------------------------------
// mafhd_front
// Accepts header words, splits the fields, looks up rate and bitrate and
// forms the numerator of the frame size division for the back end.
// ----------------------------------------------------------------------------
module mafhd_front import mafhd_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_header_word,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic        sync_ok;
  logic [1:0]  lbits;
  logic [1:0]  layer;
  logic [3:0]  br_idx;
  logic [1:0]  sr_idx;
  logic        m25;
  logic        lsf;
  logic [3:0]  rate_idx;
  logic [2:0]  kbps_row;
  logic        bad;
  logic        ok;
  logic        halve;
  logic [15:0] sr;
  logic [8:0]  br;
  logic [26:0] prod;
  logic [12:0] dec_base;
  status_t     status;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    sync_ok  = (in_header_word & SYNC_MASK) == SYNC_MASK;
    lbits    = in_header_word[18:17];
    // Layer code 3 - lbits + 1 wraps to 0 for the reserved code.
    layer    = 2'd0 - lbits;
    br_idx   = in_header_word[15:12];
    sr_idx   = in_header_word[11:10];
    m25      = !in_header_word[20];
    lsf      = m25 || !in_header_word[19];
    rate_idx = (m25 ? 4'd6 : (lsf ? 4'd3 : 4'd0)) + {2'b00, sr_idx};
    kbps_row = (lsf ? 3'd3 : 3'd0) + {1'b0, layer} - 3'd1;
    bad      = (layer == 2'd0) || (sr_idx == 2'd3) || (br_idx == 4'd15);

    if (!sync_ok) begin
      status = ST_NO_SYNC;
    end else if (bad) begin
      status = ST_BAD;
    end else if (br_idx == 4'd0) begin
      status = ST_FREE_FMT;
    end else begin
      status = ST_OK;
    end
    ok = status == ST_OK;

    sr    = (sr_idx == 2'd3) ? 16'd0 : RATE_TAB[rate_idx];
    br    = ok ? KBPS_TAB[kbps_row][br_idx] : 9'd0;
    halve = (layer == LAYER_3) && lsf;
    prod  = {18'd0, br} * {9'd0, (layer == LAYER_1) ? L1_SCALE : L23_SCALE};

    if (layer == LAYER_1) begin
      dec_base = DEC_L1;
    end else if (halve) begin
      dec_base = DEC_L23 >> 1;
    end else begin
      dec_base = DEC_L23;
    end

    q_job = '0;
    q_job.hdr.status = status;
    if (sync_ok) begin
      q_job.hdr.layer          = layer;
      q_job.hdr.is_mpeg25      = m25;
      q_job.hdr.is_lsf         = lsf;
      q_job.hdr.protection_bit = in_header_word[16];
      q_job.hdr.channel_mode   = in_header_word[7:6];
      q_job.hdr.mode_extension = in_header_word[5:4];
      q_job.hdr.padding        = in_header_word[9];
      q_job.hdr.sample_rate_hz = sr;
    end
    q_job.hdr.bitrate_kbps = br;
    if (ok) begin
      q_job.hdr.decode_bytes =
        (in_header_word[7:6] == MODE_MONO) ? dec_base : (dec_base << 1);
    end
    q_job.numer  = prod[NW-1:0];
    // A rejected header divides zero by one so the divider stays in range.
    q_job.denom  = ok ? sr : 16'd1;
    q_job.layer1 = layer == LAYER_1;
    q_job.halve  = halve;
    q_job.ok     = ok;
  end

endmodule

/* design/mafhd_fifo.sv */
// ----------------------------------------------------------------------------
// mafhd_fifo
// Small register queue between the front end and the divider pipeline.
// ----------------------------------------------------------------------------
module mafhd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == (AW+1)'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/mafhd_back.sv */
// ----------------------------------------------------------------------------
// mafhd_back
// Restoring divider pipeline, one quotient bit per stage, followed by the
// frame size finish and the output register.
// ----------------------------------------------------------------------------
module mafhd_back import mafhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output hdr_t        out_hdr,
  output logic [11:0] out_payload
);

  localparam int SW = DW + QW;

  function automatic div_stage_t div_step(div_stage_t s, int bitpos);
    logic [SW-1:0] shifted;
    div_stage_t    r;
    shifted = SW'(s.job.denom) << bitpos;
    r = s;
    if ({{(SW-NW){1'b0}}, s.job.numer} >= shifted) begin
      r.job.numer  = s.job.numer - shifted[NW-1:0];
      r.quot[bitpos] = 1'b1;
    end
    return r;
  endfunction

  div_stage_t    st_r   [QW];
  div_stage_t    st_nxt [QW];
  logic [QW-1:0] vld_r;
  logic          en;
  logic          out_valid_r;
  hdr_t          out_hdr_r;
  logic [11:0]   out_payload_r, out_payload_nxt;
  div_stage_t    head;
  logic [11:0]   fs;

  // The whole pipeline moves together whenever the output word can move.
  assign en          = !out_valid_r || out_ready;
  assign q_pop       = en && q_valid;
  assign out_valid   = out_valid_r;
  assign out_hdr     = out_hdr_r;
  assign out_payload = out_payload_r;

  assign head = '{job: q_job, quot: '0};

  for (genvar g = 0; g < QW; g++) begin : g_stage
    if (g == 0) begin : g_first
      always_comb st_nxt[g] = div_step(head, QW - 1 - g);
    end else begin : g_rest
      always_comb st_nxt[g] = div_step(st_r[g-1], QW - 1 - g);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= (g == 0) ? q_valid : vld_r[(g == 0) ? 0 : g - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  always_comb begin
    fs = st_r[QW-1].job.halve ? (st_r[QW-1].quot >> 1) : st_r[QW-1].quot;
    if (!st_r[QW-1].job.ok) begin
      out_payload_nxt = 12'd0;
    end else if (st_r[QW-1].job.layer1) begin
      out_payload_nxt =
        ((st_r[QW-1].quot + {11'd0, st_r[QW-1].job.hdr.padding}) << 2) - 12'd4;
    end else begin
      out_payload_nxt = fs + {11'd0, st_r[QW-1].job.hdr.padding} - 12'd4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hdr_r     <= st_r[QW-1].job.hdr;
      out_payload_r <= out_payload_nxt;
    end
  end

endmodule

/* design/mpeg_audio_frame_header_decoder_unit.sv */
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_decoder_unit
// Decodes MPEG-1/2/2.5 audio frame headers into fields, rates and sizes.
// ----------------------------------------------------------------------------
// One header word is taken per cycle while the queue has room, and one result
// word comes out for each, in order: field decode, table lookup and the
// bitrate multiply happen in the accepting cycle and write the queue, then
// the frame size divider follows (one quotient bit per stage, the first
// stage loaded from the queue), and last the output register. The queue of
// FIFO_DEPTH words absorbs short output stalls; a long stall fills it and
// drops in_ready.
module mpeg_audio_frame_header_decoder_unit import mafhd_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_header_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_layer,
  output logic        out_is_mpeg25,
  output logic        out_is_lsf,
  output logic        out_protection_bit,
  output logic [1:0]  out_channel_mode,
  output logic [1:0]  out_mode_extension,
  output logic        out_padding,
  output logic [15:0] out_sample_rate_hz,
  output logic [8:0]  out_bitrate_kbps,
  output logic [11:0] out_frame_payload_bytes,
  output logic [12:0] out_decode_bytes
);

  localparam int JW = $bits(job_t);

  job_t          push_job;
  logic          q_push, q_full, q_pop, q_not_empty;
  logic [JW-1:0] q_rd_bits;
  hdr_t          hdr;

  mafhd_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_header_word (in_header_word),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  mafhd_fifo #(
    .W     (JW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (q_rd_bits)
  );

  mafhd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_not_empty),
    .q_job       (job_t'(q_rd_bits)),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hdr     (hdr),
    .out_payload (out_frame_payload_bytes)
  );

  assign out_status         = hdr.status;
  assign out_layer          = hdr.layer;
  assign out_is_mpeg25      = hdr.is_mpeg25;
  assign out_is_lsf         = hdr.is_lsf;
  assign out_protection_bit = hdr.protection_bit;
  assign out_channel_mode   = hdr.channel_mode;
  assign out_mode_extension = hdr.mode_extension;
  assign out_padding        = hdr.padding;
  assign out_sample_rate_hz = hdr.sample_rate_hz;
  assign out_bitrate_kbps   = hdr.bitrate_kbps;
  assign out_decode_bytes   = hdr.decode_bytes;

endmodule

/* design/mafhd_checker.sv */
// ----------------------------------------------------------------------------
// mafhd_checker
// Port-level assertions for the frame header decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mafhd_checker import mafhd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [1:0]  out_layer,
  input logic        out_is_mpeg25,
  input logic        out_is_lsf,
  input logic        out_protection_bit,
  input logic [1:0]  out_channel_mode,
  input logic [1:0]  out_mode_extension,
  input logic        out_padding,
  input logic [15:0] out_sample_rate_hz,
  input logic [8:0]  out_bitrate_kbps,
  input logic [11:0] out_frame_payload_bytes,
  input logic [12:0] out_decode_bytes
);

  // A stalled result word holds its status and sizes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_frame_payload_bytes) && $stable(out_decode_bytes))
    else $error("stalled result word changed");

  // Without sync every field besides the status is cleared.
  a_no_sync_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NO_SYNC |-> out_layer == 2'd0
      && !out_is_mpeg25 && !out_is_lsf && out_sample_rate_hz == 16'd0
      && out_channel_mode == 2'd0 && !out_padding && !out_protection_bit
      && out_mode_extension == 2'd0)
    else $error("no-sync result carries header fields");

  // Any rejected header gives no bitrate and no sizes.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_bitrate_kbps == 9'd0
      && out_frame_payload_bytes == 12'd0 && out_decode_bytes == 13'd0)
    else $error("rejected header carries sizes");

  // A good header has a real layer, rate, bitrate and buffer size.
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_layer != 2'd0
      && out_sample_rate_hz != 16'd0 && out_bitrate_kbps != 9'd0
      && out_decode_bytes != 13'd0)
    else $error("good header with empty fields");

  // A Layer I frame size is a whole number of four-byte slots.
  a_l1_slots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && out_layer == LAYER_1
      |-> out_frame_payload_bytes[1:0] == 2'd0)
    else $error("layer I size not slot aligned");

endmodule

bind mpeg_audio_frame_header_decoder_unit mafhd_checker u_mafhd_checker (.*);

/* test/tb_mpeg_audio_frame_header_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mpeg_audio_frame_header_decoder_unit
// Self-checking bench for the MPEG audio frame header decoder. A directed set
// of headers covers every layer, version, table corner and error case; a long
// random run follows, made mostly of well-formed headers. Each accepted word
// is decoded by an independent software decoder and the result words are
// compared field by field, in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_mpeg_audio_frame_header_decoder_unit;
  import mafhd_pkg::*;

  // Header version codes (bits 20..19) and layer codes (bits 18..17).
  localparam logic [1:0] VER_25    = 2'b00;
  localparam logic [1:0] VER_RSV   = 2'b01;
  localparam logic [1:0] VER_2     = 2'b10;
  localparam logic [1:0] VER_1     = 2'b11;
  localparam logic [1:0] LBITS_RSV = 2'b00;
  localparam logic [1:0] LBITS_L3  = 2'b01;
  localparam logic [1:0] LBITS_L2  = 2'b10;
  localparam logic [1:0] LBITS_L1  = 2'b11;
  localparam logic [3:0] BR_FREE   = 4'd0;
  localparam logic [3:0] BR_BAD    = 4'd15;
  localparam logic [1:0] SR_RSV    = 2'd3;
  localparam logic [8:0] TAIL_MONO = 9'h0C0;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CALM_TAIL    = 120;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE       = 40;

  localparam int unsigned SAMPLE_RATES [9] = '{
    44100, 48000, 32000, 22050, 24000, 16000, 11025, 12000, 8000
  };

  localparam int unsigned KBPS_ROWS [6][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };

  typedef struct packed {
    status_t     status;
    logic [1:0]  layer;
    logic        is_mpeg25;
    logic        is_lsf;
    logic        protection_bit;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic        padding;
    logic [15:0] sample_rate_hz;
    logic [8:0]  bitrate_kbps;
    logic [11:0] frame_payload_bytes;
    logic [12:0] decode_bytes;
  } frame_info_t;

  typedef struct {
    logic [31:0] word;
    bit          wait_drain;
  } header_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_header_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [1:0]  out_layer;
  logic        out_is_mpeg25;
  logic        out_is_lsf;
  logic        out_protection_bit;
  logic [1:0]  out_channel_mode;
  logic [1:0]  out_mode_extension;
  logic        out_padding;
  logic [15:0] out_sample_rate_hz;
  logic [8:0]  out_bitrate_kbps;
  logic [11:0] out_frame_payload_bytes;
  logic [12:0] out_decode_bytes;

  header_item_t pending_headers[$];
  frame_info_t  expected_frames[$];
  int           mismatches = 0;
  int           headers_sent = 0;
  int           frames_seen = 0;
  int           gap_cnt = 0;
  int           gap_pct = 20;
  int           hold_cnt = 0;
  int           stall_pct = 20;
  bit           long_hold_done = 1'b0;

  mpeg_audio_frame_header_decoder_unit DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_header_word          (in_header_word),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_status              (out_status),
    .out_layer               (out_layer),
    .out_is_mpeg25           (out_is_mpeg25),
    .out_is_lsf              (out_is_lsf),
    .out_protection_bit      (out_protection_bit),
    .out_channel_mode        (out_channel_mode),
    .out_mode_extension      (out_mode_extension),
    .out_padding             (out_padding),
    .out_sample_rate_hz      (out_sample_rate_hz),
    .out_bitrate_kbps        (out_bitrate_kbps),
    .out_frame_payload_bytes (out_frame_payload_bytes),
    .out_decode_bytes        (out_decode_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] make_header(logic [1:0] ver, logic [1:0] lbits,
                                              logic prot, logic [3:0] br_idx,
                                              logic [1:0] sr_idx, logic pad,
                                              logic [8:0] tail);
    return {11'h7FF, ver, lbits, prot, br_idx, sr_idx, pad, tail};
  endfunction

  function automatic frame_info_t decode_header(logic [31:0] hw);
    frame_info_t r;
    logic [3:0]  br_idx;
    logic [1:0]  sr_idx;
    int unsigned sr, br, ch, fs, row, payload, dec;
    r = '0;
    if ((hw & SYNC_MASK) != SYNC_MASK) begin
      r.status = ST_NO_SYNC;
      return r;
    end
    case (hw[18:17])
      LBITS_L1: r.layer = 2'd1;
      LBITS_L2: r.layer = 2'd2;
      LBITS_L3: r.layer = 2'd3;
      default:  r.layer = 2'd0;
    endcase
    r.is_mpeg25      = ~hw[20];
    r.is_lsf         = ~hw[20] | ~hw[19];
    r.protection_bit = hw[16];
    br_idx           = hw[15:12];
    sr_idx           = hw[11:10];
    r.padding        = hw[9];
    r.channel_mode   = hw[7:6];
    r.mode_extension = hw[5:4];
    sr = 0;
    if (sr_idx != SR_RSV) begin
      row = r.is_mpeg25 ? 6 : (r.is_lsf ? 3 : 0);
      sr = SAMPLE_RATES[row + sr_idx];
      r.sample_rate_hz = 16'(sr);
    end
    if (r.layer == 2'd0 || sr_idx == SR_RSV || br_idx == BR_BAD) begin
      r.status = ST_BAD;
    end else if (br_idx == BR_FREE) begin
      r.status = ST_FREE_FMT;
    end else begin
      r.status = ST_OK;
      row = (r.is_lsf ? 3 : 0) + r.layer - 1;
      br = KBPS_ROWS[row][br_idx];
      ch = (r.channel_mode == MODE_MONO) ? 1 : 2;
      if (r.layer == LAYER_1) begin
        payload = 4 * (int'(L1_SCALE) * br / sr + r.padding) - 4;
        dec = int'(DEC_L1) * ch;
      end else begin
        fs = int'(L23_SCALE) * br / sr;
        dec = int'(DEC_L23) * ch;
        // Layer III at the low sampling rates carries half the granules.
        if (r.layer == LAYER_3 && r.is_lsf) begin
          fs = fs >> 1;
          dec = dec >> 1;
        end
        payload = fs + r.padding - 4;
      end
      r.bitrate_kbps = 9'(br);
      r.frame_payload_bytes = 12'(payload);
      r.decode_bytes = 13'(dec);
    end
    return r;
  endfunction

  function automatic logic [31:0] random_header();
    int unsigned pick;
    logic [31:0] hw;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      hw = make_header(2'($urandom_range(0, 3)), 2'($urandom_range(1, 3)),
                       1'($urandom), 4'($urandom_range(1, 14)),
                       2'($urandom_range(0, 2)), 1'($urandom), 9'($urandom));
    end else if (pick < 86) begin
      hw = {11'h7FF, 21'($urandom)};
    end else if (pick < 94) begin
      hw = {11'h7FF, 21'($urandom)};
      hw[21 + $urandom_range(0, 10)] = 1'b0;
    end else begin
      hw = $urandom;
    end
    return hw;
  endfunction

  task automatic queue_header(logic [31:0] hw, bit drain);
    header_item_t item;
    item.word = hw;
    item.wait_drain = drain;
    pending_headers.push_back(item);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Sender: a new word is loaded only when the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_frames.push_back(decode_header(in_header_word));
        headers_sent++;
        if (headers_sent % 100 == 0) gap_pct = 25 * $urandom_range(0, 2);
      end
      if (!in_valid || in_ready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid <= 1'b0;
        end else if (pending_headers.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_headers[0].wait_drain && expected_frames.size() != 0) begin
          in_valid <= 1'b0;
        end else if (pending_headers.size() > CALM_TAIL &&
                     $urandom_range(0, 99) < gap_pct) begin
          gap_cnt = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_header_word <= pending_headers[0].word;
          void'(pending_headers.pop_front());
        end
      end
    end
  end

  // Receiver: checks each word taken and stalls in random bursts.
  always @(posedge clk) begin
    frame_info_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        frames_seen++;
        if (frames_seen % 128 == 0) stall_pct = 20 * $urandom_range(0, 2);
        if (expected_frames.size() == 0) begin
          $error("result word with no header pending");
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("layer", want.layer, out_layer);
          compare_field("is_mpeg25", want.is_mpeg25, out_is_mpeg25);
          compare_field("is_lsf", want.is_lsf, out_is_lsf);
          compare_field("protection_bit", want.protection_bit, out_protection_bit);
          compare_field("channel_mode", want.channel_mode, out_channel_mode);
          compare_field("mode_extension", want.mode_extension, out_mode_extension);
          compare_field("padding", want.padding, out_padding);
          compare_field("sample_rate_hz", want.sample_rate_hz, out_sample_rate_hz);
          compare_field("bitrate_kbps", want.bitrate_kbps, out_bitrate_kbps);
          compare_field("frame_payload_bytes", want.frame_payload_bytes,
                        out_frame_payload_bytes);
          compare_field("decode_bytes", want.decode_bytes, out_decode_bytes);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && headers_sent >= 400) begin
        // One long stall so the pipeline and its queue fill and in_ready drops.
        long_hold_done = 1'b1;
        hold_cnt = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (pending_headers.size() > CALM_TAIL &&
                   $urandom_range(0, 99) < stall_pct) begin
        hold_cnt = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    queue_header(32'h0000_0000, 1'b0);
    queue_header(32'hFFFF_FFFF, 1'b0);
    queue_header(32'hFFDF_FFFF, 1'b0);
    queue_header(32'h7FFF_FFFF, 1'b0);
    queue_header(32'hFFE0_0000, 1'b0);
    queue_header(make_header(VER_1, LBITS_L3, 1'b1, 4'd9, 2'd0, 1'b0, 9'h000), 1'b0);
    queue_header(make_header(VER_1, LBITS_L2, 1'b0, 4'd14, 2'd1, 1'b1, TAIL_MONO), 1'b0);
    queue_header(make_header(VER_1, LBITS_L1, 1'b1, 4'd14, 2'd2, 1'b1, 9'h000), 1'b0);
    queue_header(make_header(VER_1, LBITS_L1, 1'b0, 4'd1, 2'd1, 1'b0, 9'h1FF), 1'b0);
    queue_header(make_header(VER_1, LBITS_L3, 1'b1, 4'd1, 2'd2, 1'b0, 9'h030), 1'b0);
    queue_header(make_header(VER_2, LBITS_L3, 1'b1, 4'd8, 2'd0, 1'b0, TAIL_MONO), 1'b0);
    queue_header(make_header(VER_2, LBITS_L3, 1'b1, 4'd14, 2'd2, 1'b1, 9'h000), 1'b0);
    queue_header(make_header(VER_2, LBITS_L1, 1'b1, 4'd14, 2'd2, 1'b1, 9'h000), 1'b0);
    queue_header(make_header(VER_2, LBITS_L2, 1'b1, 4'd1, 2'd0, 1'b0, 9'h000), 1'b0);
    queue_header(make_header(VER_25, LBITS_L3, 1'b1, 4'd14, 2'd2, 1'b1, 9'h000), 1'b0);
    queue_header(make_header(VER_25, LBITS_L2, 1'b1, 4'd14, 2'd2, 1'b1, TAIL_MONO), 1'b0);
    queue_header(make_header(VER_RSV, LBITS_L1, 1'b1, 4'd5, 2'd1, 1'b0, 9'h000), 1'b0);
    queue_header(make_header(VER_RSV, LBITS_L3, 1'b0, 4'd14, 2'd2, 1'b1, 9'h000), 1'b0);
    queue_header(make_header(VER_1, LBITS_RSV, 1'b1, 4'd9, 2'd0, 1'b0, 9'h000), 1'b0);
    queue_header(make_header(VER_1, LBITS_L3, 1'b1, 4'd9, SR_RSV, 1'b0, 9'h000), 1'b0);
    queue_header(make_header(VER_1, LBITS_L2, 1'b1, BR_BAD, 2'd0, 1'b0, 9'h000), 1'b0);
    queue_header(make_header(VER_1, LBITS_L2, 1'b1, BR_FREE, 2'd0, 1'b0, 9'h000), 1'b0);
    queue_header(make_header(VER_2, LBITS_L1, 1'b1, BR_FREE, SR_RSV, 1'b1, 9'h000), 1'b0);
    queue_header(make_header(VER_25, LBITS_RSV, 1'b1, BR_FREE, SR_RSV, 1'b0, 9'h000), 1'b0);
    // The first random word and one in the middle wait for the pipeline to empty.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      queue_header(random_header(), i == 0 || i == RANDOM_ITEMS / 2);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_headers.size() != 0 || in_valid) @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
